// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define UPC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UPC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/upc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upc_pkg
// shared types, character codes and hex helpers of the url percent codec
// ----------------------------------------------------------------------------
package upc_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_UNDER = 8'h5F;
   localparam logic [7:0] CHAR_TILDE = 8'h7E;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_BAD_HEX = 2'd1;
   localparam logic [1:0] ERR_TRUNC   = 2'd2;

   localparam logic [7:0] HEX_LETTER_BIAS = 8'd55;
   localparam logic [7:0] HEX_DIGIT_BIAS  = 8'd48;

   // one queued job: a single result, or a three-result escape of data
   typedef struct packed {
      logic       triple;
      logic [7:0] data;
      logic       done;
      logic [1:0] err;
   } job_type;

   // bit 4 set marks a byte that is no hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'd16;
      if (c inside {[8'h30:8'h39]}) v = {1'b0, 4'(c - 8'h30)};
      else if (c inside {[8'h41:8'h46]}) v = {1'b0, 4'(c - 8'h37)};
      else if (c inside {[8'h61:8'h66]}) v = {1'b0, 4'(c - 8'h57)};
      return v;
   endfunction

   function automatic logic is_unreserved(input logic [7:0] c);
      return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                        CHAR_DASH, CHAR_UNDER, CHAR_DOT, CHAR_TILDE});
   endfunction

   function automatic logic [7:0] nibble_to_hex(input logic [3:0] v);
      return (v > 4'd9) ? ({4'd0, v} + HEX_LETTER_BIAS) : ({4'd0, v} + HEX_DIGIT_BIAS);
   endfunction

endpackage

// File: rtl/upc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upc_req_if
// input byte channel of the url percent codec
// ----------------------------------------------------------------------------
interface upc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

// File: rtl/upc_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upc_rsp_if
// result byte channel of the url percent codec
// ----------------------------------------------------------------------------
interface upc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       string_done;
   logic [1:0] error;

   modport source (output valid, output out_byte, output run_last,
                   output string_done, output error, input ready);
   modport sink (input valid, input out_byte, input run_last,
                 input string_done, input error, output ready);
endinterface

// File: rtl/url_percent_codec_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_codec_unit
// byte-stream url percent encoder and decoder, direction set by csr
// ----------------------------------------------------------------------------
// channel   dir  handshake        payload
// req_chan  in   valid / ready    in_byte, end_of_string
// rsp_chan  out  valid / ready    out_byte, run_last, string_done, error
// csr       in   csr_wr_en        csr_wr_data (direction)
//
// one item is taken per cycle while the job queue has room; the back end
// emits one result per cycle while the output is ready, so an encoded escape holds it for all three of its results
// the first result passes through the job queue and then the output register before it is valid
// the job queue depth sets how long input keeps flowing while the output stalls
// reset is synchronous, active high, and needs no clearing pass
// ----------------------------------------------------------------------------
module url_percent_codec_unit #(
   parameter int QueueDepth = upc_pkg::QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   upc_req_if.sink   req_chan,
   upc_rsp_if.source rsp_chan,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data
);

   logic             push;
   logic             q_full;
   logic             q_empty;
   logic             pop;
   upc_pkg::job_type push_job;
   upc_pkg::job_type head;

   upc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .push        (push),
      .push_job    (push_job)
   );

   upc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (pop),
      .empty    (q_empty),
      .head     (head)
   );

   upc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .head    (head),
      .pop     (pop),
      .rsp     (rsp_chan)
   );

endmodule

// File: rtl/upc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upc_queue
// small job queue between the classifying front and the emitting back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module upc_queue #(
   parameter int Depth = upc_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  upc_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output upc_pkg::job_type head
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   upc_pkg::job_type mem_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   assign full  = (count_ff == CntW'(Depth));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CntW'(push) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   `UPC_ASSERT_SAME(a_no_push_full, full, !push, "push into a full queue")
   `UPC_ASSERT_SAME(a_no_pop_empty, empty, !pop, "pop from an empty queue")
   `UPC_ASSERT_SAME(a_count_range, 1'b1, count_ff <= CntW'(Depth), "queue count overflow")

endmodule

// File: rtl/upc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upc_front
// accepts bytes, tracks the escape state and queues one job per result run
// ----------------------------------------------------------------------------
module upc_front (
   input  logic             clock,
   input  logic             reset,
   upc_req_if.sink          req,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data,
   input  logic             q_full,
   output logic             push,
   output upc_pkg::job_type push_job
);

   typedef enum logic [2:0] {
      ESC_IDLE = 3'b001,
      ESC_PCT  = 3'b010,
      ESC_HIGH = 3'b100
   } esc_type;

   esc_type    phase_ff, phase_in;
   logic [3:0] high_ff, high_in;
   logic       direction_ff, direction_in;
   logic       accept;
   logic       emit;
   logic [7:0] c;
   logic       done;
   logic [4:0] hex;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign c         = req.in_byte;
   assign done      = req.end_of_string;
   assign hex       = upc_pkg::hex_value(c);
   assign push      = accept && emit;

   always_comb begin
      phase_in          = phase_ff;
      high_in           = high_ff;
      direction_in      = direction_ff;
      emit              = 1'b0;
      push_job.triple   = 1'b0;
      push_job.data     = c;
      push_job.done     = done;
      push_job.err      = upc_pkg::ERR_NONE;

      if (!direction_ff) begin
         emit = 1'b1;
         if (upc_pkg::is_unreserved(c)) begin
            push_job.data = c;
         end else if (c == upc_pkg::CHAR_SPACE) begin
            push_job.data = upc_pkg::CHAR_PLUS;
         end else begin
            push_job.triple = 1'b1;
         end
      end else begin
         case (phase_ff)
            ESC_PCT: begin
               if (hex[4]) begin
                  emit          = 1'b1;
                  push_job.data = 8'd0;
                  push_job.err  = upc_pkg::ERR_BAD_HEX;
               end else if (done) begin
                  emit          = 1'b1;
                  push_job.data = 8'd0;
                  push_job.err  = upc_pkg::ERR_TRUNC;
               end
            end
            ESC_HIGH: begin
               emit = 1'b1;
               if (hex[4]) begin
                  push_job.data = 8'd0;
                  push_job.err  = upc_pkg::ERR_BAD_HEX;
               end else begin
                  push_job.data = {high_ff, hex[3:0]};
               end
            end
            default: begin
               if (c == upc_pkg::CHAR_PLUS) begin
                  emit          = 1'b1;
                  push_job.data = upc_pkg::CHAR_SPACE;
               end else if (c == upc_pkg::CHAR_PCT) begin
                  if (done) begin
                     emit          = 1'b1;
                     push_job.data = 8'd0;
                     push_job.err  = upc_pkg::ERR_TRUNC;
                  end
               end else begin
                  emit = 1'b1;
               end
            end
         endcase
      end

      if (accept) begin
         phase_in = ESC_IDLE;
         if (direction_ff && !done) begin
            case (phase_ff)
               ESC_PCT: begin
                  if (!hex[4]) begin
                     phase_in = ESC_HIGH;
                     high_in  = hex[3:0];
                  end
               end
               ESC_HIGH: phase_in = ESC_IDLE;
               default: begin
                  if (c == upc_pkg::CHAR_PCT) phase_in = ESC_PCT;
               end
            endcase
         end
      end

      // a csr write drops any open escape
      if (csr_wr_en) begin
         direction_in = csr_wr_data;
         phase_in     = ESC_IDLE;
         high_in      = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ESC_IDLE;
         high_ff      <= 4'd0;
         direction_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         high_ff      <= high_in;
         direction_ff <= direction_in;
      end
   end

endmodule

// File: rtl/upc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upc_back
// expands queued jobs into result items behind an output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module upc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  upc_pkg::job_type head,
   output logic             pop,
   upc_rsp_if.source        rsp
);

   typedef enum logic [2:0] {
      SEQ_HEAD = 3'b001,
      SEQ_HI   = 3'b010,
      SEQ_LO   = 3'b100
   } seq_type;

   seq_type    seq_ff, seq_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       done_ff;
   logic [1:0] err_ff;
   logic       load;

   assign load = !q_empty && (!valid_ff || rsp.ready);

   always_comb begin
      seq_in  = seq_ff;
      byte_in = head.data;
      last_in = 1'b1;
      pop     = 1'b0;
      case (seq_ff)
         SEQ_HI: begin
            byte_in = upc_pkg::nibble_to_hex(head.data[7:4]);
            last_in = 1'b0;
            if (load) seq_in = SEQ_LO;
         end
         SEQ_LO: begin
            byte_in = upc_pkg::nibble_to_hex(head.data[3:0]);
            pop     = load;
            if (load) seq_in = SEQ_HEAD;
         end
         default: begin
            if (head.triple) begin
               byte_in = upc_pkg::CHAR_PCT;
               last_in = 1'b0;
               if (load) seq_in = SEQ_HI;
            end else begin
               pop = load;
            end
         end
      endcase
      valid_in = load ? 1'b1 : (valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff   <= SEQ_HEAD;
         valid_ff <= 1'b0;
      end else begin
         seq_ff   <= seq_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
         done_ff <= head.done;
         err_ff  <= head.err;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.out_byte    = byte_ff;
   assign rsp.run_last    = last_ff;
   assign rsp.string_done = done_ff;
   assign rsp.error       = err_ff;

   `UPC_ASSERT_SAME(a_mid_escape_head, seq_ff != SEQ_HEAD, !q_empty && head.triple, "escape sequencing without a triple job")
   `UPC_ASSERT_SAME(a_error_single, valid_ff && (err_ff != upc_pkg::ERR_NONE), last_ff, "error result not alone")
   `UPC_ASSERT_NEXT(a_run_continues, valid_ff && rsp.ready && !last_ff, valid_ff, "escape run broken")

endmodule
